### design/aptl_pkg.sv
// ----------------------------------------------------------------------------
// aptl_pkg: shared types and constants of the pose tracking law
// Item and configuration structs, register indexes, CORDIC tables and
// pipeline latencies used by the front, queue, arithmetic units and back.
// ----------------------------------------------------------------------------
package aptl_pkg;

    // Configuration register indexes
    localparam int CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LONG  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_LAT   = 8'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_HEAD  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_WB_LEN     = 8'd3;
    localparam logic [15:0] CFG_RESET_VAL = 16'd256;

    // CORDIC step count and arctangent table, Q.16 radians
    localparam int STEPS = 16;
    localparam int ATAN_TAB [16] = '{
        51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
        256, 128, 64, 32, 16, 8, 4, 2
    };

    // Steering limit, Q2.12 radians (pi/2)
    localparam logic signed [13:0] STEER_MAX = 14'sd6434;

    // Latencies of the arithmetic units, in enabled cycles
    localparam int TRIG_LAT = 18;
    localparam int DIV_LAT  = 44;
    localparam int MUL_LAT  = 5;

    typedef struct packed {
        logic [15:0] gain_long;
        logic [15:0] gain_lat;
        logic [15:0] gain_head;
        logic [15:0] wb_len;
    } cfg_t;

    // Classified item: errors plus the fields the back still needs
    typedef struct packed {
        logic signed [32:0] ex;
        logic signed [32:0] ey;
        logic signed [16:0] eth;
        logic signed [15:0] ath;
        logic signed [15:0] v;
        logic signed [13:0] phi;
    } item_t;

    // Steering override from the ratio stage
    typedef enum logic [1:0] {
        SPEC_NONE,
        SPEC_ZERO,
        SPEC_MAX
    } spec_t;

endpackage

### design/aptl_front.sv
// ----------------------------------------------------------------------------
// aptl_front: input stage of the pose tracking law
// Accepts input beats, forms the position and heading errors and hands
// the classified item to the queue.
// ----------------------------------------------------------------------------
module aptl_front (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    // actual_x, actual_y, actual_heading, target_x, target_y,
    // target_heading, target_speed, target_steer, 2 zero bits
    input  logic [191:0]        s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output aptl_pkg::item_t     q_item
);

    logic                   vld_reg;
    logic                   vld_next;
    aptl_pkg::item_t        item_reg;
    aptl_pkg::item_t        item_next;
    logic                   s_accept;

    logic signed [31:0] ax, ay, tx, ty;
    logic signed [15:0] ath, tth;

    assign s_tready = !vld_reg || !q_full;
    assign s_accept = s_tvalid && s_tready;
    assign q_push   = vld_reg && !q_full;
    assign q_item   = item_reg;

    // Unpack the beat and form the errors
    always_comb begin
        ax = $signed(s_tdata[31:0]);
        ay = $signed(s_tdata[63:32]);
        ath = $signed(s_tdata[79:64]);
        tx = $signed(s_tdata[111:80]);
        ty = $signed(s_tdata[143:112]);
        tth = $signed(s_tdata[159:144]);
        item_next.ex = {tx[31], tx} - {ax[31], ax};
        item_next.ey = {ty[31], ty} - {ay[31], ay};
        item_next.eth = {tth[15], tth} - {ath[15], ath};
        item_next.ath = ath;
        item_next.v = $signed(s_tdata[175:160]);
        item_next.phi = $signed(s_tdata[189:176]);
    end

    // Hold the item until the queue takes it
    always_comb begin
        vld_next = vld_reg;
        if (s_accept) begin
            vld_next = 1'b1;
        end else if (q_push) begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= 1'b0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg <= item_next;
        end
    end

endmodule

### design/aptl_queue.sv
// ----------------------------------------------------------------------------
// aptl_queue: item queue between front and back
// Small register FIFO that decouples input acceptance from the
// arithmetic pipeline.
// ----------------------------------------------------------------------------
module aptl_queue #(
    parameter int DEPTH = 4
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  aptl_pkg::item_t     din,
    output logic                full,
    input  logic                pop,
    output logic                valid,
    output aptl_pkg::item_t     dout
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    aptl_pkg::item_t    mem_reg [DEPTH];
    logic [PW-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]      count_reg, count_next;

    assign full  = (count_reg == CW'(DEPTH));
    assign valid = (count_reg != '0);
    assign dout  = mem_reg[rd_ptr_reg];

    // Advance pointers and count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

`ifndef SYNTH
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != '0)
        else $error("queue popped while empty");
    a_push_grows: assert property (@(posedge aclk) disable iff (!aresetn)
        push && !pop |=> count_reg == $past(count_reg) + 1'b1)
        else $error("queue count did not follow push");
`endif

endmodule

### design/aptl_trig.sv
// ----------------------------------------------------------------------------
// aptl_trig: pipelined sine and cosine
// Reduces a Q.16 angle into [-pi/2, pi/2], runs a 16-step rotation CORDIC,
// one step per stage, and rounds the results to Q.24.
// ----------------------------------------------------------------------------
module aptl_trig (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [21:0]  ang_i,
    output logic signed [26:0]  cos_o,
    output logic signed [26:0]  sin_o
);

    localparam int STEPS = aptl_pkg::STEPS;
    localparam logic signed [22:0] PI_Q16      = 23'sd205887;
    localparam logic signed [22:0] HALF_PI_Q16 = 23'sd102944;
    localparam logic signed [22:0] TWO_PI_Q16  = 23'sd411775;
    localparam logic signed [32:0] GAIN_Q30    = 33'sd652032874;
    localparam logic signed [32:0] HALF_LSB    = 33'sd32;

    logic signed [32:0] x_reg [0:STEPS];
    logic signed [32:0] y_reg [0:STEPS];
    logic signed [22:0] z_reg [0:STEPS];
    logic               neg_reg [0:STEPS];
    logic signed [26:0] cos_reg, sin_reg;

    logic signed [22:0] red_ang;
    logic               red_neg;
    logic signed [32:0] x_fin, y_fin;

    // Fold the angle into [-pi/2, pi/2]
    always_comb begin
        red_ang = {ang_i[21], ang_i};
        red_neg = 1'b0;
        for (int k = 0; k < 3; k++) begin
            if (red_ang > PI_Q16) begin
                red_ang = red_ang - TWO_PI_Q16;
            end else if (red_ang < -PI_Q16) begin
                red_ang = red_ang + TWO_PI_Q16;
            end
        end
        if (red_ang > HALF_PI_Q16) begin
            red_ang = red_ang - PI_Q16;
            red_neg = 1'b1;
        end else if (red_ang < -HALF_PI_Q16) begin
            red_ang = red_ang + PI_Q16;
            red_neg = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            x_reg[0]   <= GAIN_Q30;
            y_reg[0]   <= '0;
            z_reg[0]   <= red_ang;
            neg_reg[0] <= red_neg;
        end
    end

    // One rotation step per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_step
        localparam logic signed [22:0] ZS = 23'(aptl_pkg::ATAN_TAB[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (z_reg[i] >= 0) begin
                    x_reg[i+1] <= x_reg[i] - (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] + (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] - ZS;
                end else begin
                    x_reg[i+1] <= x_reg[i] + (y_reg[i] >>> i);
                    y_reg[i+1] <= y_reg[i] - (x_reg[i] >>> i);
                    z_reg[i+1] <= z_reg[i] + ZS;
                end
                neg_reg[i+1] <= neg_reg[i];
            end
        end
    end

    // Undo the fold and round to Q.24
    always_comb begin
        x_fin = neg_reg[STEPS] ? -x_reg[STEPS] : x_reg[STEPS];
        y_fin = neg_reg[STEPS] ? -y_reg[STEPS] : y_reg[STEPS];
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cos_reg <= 27'((x_fin + HALF_LSB) >>> 6);
            sin_reg <= 27'((y_fin + HALF_LSB) >>> 6);
        end
    end

    assign cos_o = cos_reg;
    assign sin_o = sin_reg;

endmodule

### design/aptl_div.sv
// ----------------------------------------------------------------------------
// aptl_div: pipelined tangent divider
// Forms tan = sin * 2^16 / cos with a truncating quotient, one quotient
// bit per stage; a zero cosine gives +-2^40 by the sign of sin.
// ----------------------------------------------------------------------------
module aptl_div (
    input  logic                aclk,
    input  logic                en,
    input  logic signed [26:0]  sin_i,
    input  logic signed [26:0]  cos_i,
    output logic signed [43:0]  tan_o
);

    localparam int QW = 42;
    localparam logic signed [43:0] TAN_CAP = 44'sd1 <<< 40;

    logic [QW-1:0]  dq_reg  [0:QW];
    logic [25:0]    rem_reg [0:QW];
    logic [25:0]    dv_reg  [0:QW];
    logic           neg_reg [0:QW];
    logic           cap_reg [0:QW];
    logic           capn_reg [0:QW];
    logic signed [43:0] tan_reg;

    logic [26:0] abs_s, abs_c;

    assign abs_s = sin_i[26] ? 27'(-sin_i) : 27'(sin_i);
    assign abs_c = cos_i[26] ? 27'(-cos_i) : 27'(cos_i);

    // Load magnitudes and signs
    always_ff @(posedge aclk) begin
        if (en) begin
            dq_reg[0]   <= {abs_s[25:0], 16'b0};
            rem_reg[0]  <= '0;
            dv_reg[0]   <= abs_c[25:0];
            neg_reg[0]  <= sin_i[26] ^ cos_i[26];
            cap_reg[0]  <= (cos_i == '0);
            capn_reg[0] <= sin_i[26];
        end
    end

    // One restoring step per stage
    for (genvar i = 0; i < QW; i++) begin : g_step
        logic [26:0] rem_sh;
        logic        ge;
        assign rem_sh = {rem_reg[i], dq_reg[i][QW-1]};
        assign ge     = (rem_sh >= {1'b0, dv_reg[i]});
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[i+1]  <= ge ? 26'(rem_sh - {1'b0, dv_reg[i]}) : rem_sh[25:0];
                dq_reg[i+1]   <= {dq_reg[i][QW-2:0], ge};
                dv_reg[i+1]   <= dv_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                cap_reg[i+1]  <= cap_reg[i];
                capn_reg[i+1] <= capn_reg[i];
            end
        end
    end

    // Apply sign or the cap
    always_ff @(posedge aclk) begin
        if (en) begin
            if (cap_reg[QW]) begin
                tan_reg <= capn_reg[QW] ? -TAN_CAP : TAN_CAP;
            end else if (neg_reg[QW]) begin
                tan_reg <= -$signed({2'b0, dq_reg[QW]});
            end else begin
                tan_reg <= $signed({2'b0, dq_reg[QW]});
            end
        end
    end

    assign tan_o = tan_reg;

endmodule

### design/aptl_back.sv
// ----------------------------------------------------------------------------
// aptl_back: arithmetic pipeline and result register
// Rotates the error into the vehicle frame, forms the speed command,
// the steering numerator and denominator, normalizes them and takes the
// arctangent with a vectoring CORDIC. The whole pipeline stalls as one.
// ----------------------------------------------------------------------------
module aptl_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  aptl_pkg::cfg_t      cfg,
    input  logic                q_valid,
    input  aptl_pkg::item_t     q_item,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic signed [15:0]  m_speed,
    output logic signed [13:0]  m_steer,
    output logic                m_zflag
);

    localparam int TL    = aptl_pkg::TRIG_LAT;
    localparam int DL    = aptl_pkg::DIV_LAT;
    localparam int ML    = aptl_pkg::MUL_LAT;
    localparam int STEPS = aptl_pkg::STEPS;
    localparam int DLY   = DL - ML;
    // item reg, trig, divider, six ratio stages, CORDIC steps, result reg
    localparam int LAT   = TL + DL + 6 + STEPS + 2;

    logic               en;
    logic [LAT-1:0]     vld_reg;

    logic signed [16:0] k1, ky, k3, len;

    // Item and sideband up to the trig outputs
    logic signed [32:0] ex_d  [0:TL];
    logic signed [32:0] ey_d  [0:TL];
    logic signed [16:0] eth_d [0:TL];
    logic signed [15:0] v_d   [0:TL];
    logic signed [15:0] ath0_reg;
    logic signed [13:0] phi0_reg;

    logic signed [26:0] c1, s1, c2, s2, c3, s3;
    logic signed [43:0] tn;

    // Multiply chain
    logic signed [59:0] pcex_reg, psey_reg, pcey_reg, psex_reg;
    logic signed [42:0] pvc_reg;
    logic signed [33:0] pke_reg;
    logic signed [15:0] v1_reg, v2_reg, v3_reg, v4_reg;
    logic signed [36:0] exl_reg, eyl_reg;
    logic signed [34:0] vc2_reg, vc3_reg;
    logic signed [50:0] kel_reg;
    logic signed [53:0] kx_reg, kye_reg;
    logic signed [46:0] t3a_reg, t3b_reg;
    logic signed [54:0] u24_reg;
    logic signed [45:0] r2_reg;

    logic signed [60:0] sum_x, sum_y;

    // Delay to the divider output
    logic signed [38:0] u8_d [0:DLY];
    logic signed [62:0] t2_d [0:DLY];
    logic signed [46:0] t3_d [0:DLY];
    logic signed [15:0] v_e  [0:DLY];

    // Ratio stages
    logic signed [59:0] vt_reg;
    logic signed [62:0] t2n_reg;
    logic signed [46:0] t3n_reg;
    logic signed [38:0] u8n_reg, u8m_reg;
    logic signed [64:0] num_reg;
    logic signed [54:0] den_reg;
    logic [63:0]        a3_reg, a4_reg, a5_reg;
    logic [54:0]        b3_reg, b4_reg, b5_reg;
    logic               sneg3_reg, sneg4_reg, sneg5_reg;
    logic               zf3_reg, zf4_reg, zf5_reg;
    logic               denz3_reg, denz4_reg, denz5_reg;
    logic signed [15:0] spd3_reg, spd4_reg, spd5_reg;
    logic [7:0]         bnz_reg;
    logic [2:0]         bmsb_reg [8];
    logic               rdir_reg;
    logic [5:0]         amt_reg;

    logic [63:0]        m_or;
    logic [7:0]         bnz_c;
    logic [2:0]         bmsb_c [8];
    logic [5:0]         msb_c;
    logic [63:0]        a_sh, b_sh;
    logic [64:0]        num_abs;
    logic [54:0]        den_abs;
    logic signed [15:0] spd_c;
    aptl_pkg::spec_t    spec_c;

    // Vectoring CORDIC
    logic signed [43:0] cx_reg [0:STEPS];
    logic signed [43:0] cy_reg [0:STEPS];
    logic signed [19:0] cz_reg [0:STEPS];
    aptl_pkg::spec_t    cs_reg [0:STEPS];
    logic               cn_reg [0:STEPS];
    logic               cf_reg [0:STEPS];
    logic signed [15:0] cv_reg [0:STEPS];

    logic signed [19:0] r_c;
    logic signed [13:0] st_c;

    logic signed [15:0] speed_reg;
    logic signed [13:0] steer_reg;
    logic               zf_reg;

    assign en       = !vld_reg[LAT-1] || m_tready;
    assign q_pop    = en && q_valid;
    assign m_tvalid = vld_reg[LAT-1];
    assign m_speed  = speed_reg;
    assign m_steer  = steer_reg;
    assign m_zflag  = zf_reg;

    assign k1  = $signed({1'b0, cfg.gain_long});
    assign ky  = $signed({1'b0, cfg.gain_lat});
    assign k3  = $signed({1'b0, cfg.gain_head});
    assign len = $signed({1'b0, cfg.wb_len});

    // Advance valid bits with the pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[LAT-2:0], q_valid};
        end
    end

    // Take the item and delay the sideband to the trig outputs
    always_ff @(posedge aclk) begin
        if (en) begin
            ex_d[0]  <= q_item.ex;
            ey_d[0]  <= q_item.ey;
            eth_d[0] <= q_item.eth;
            v_d[0]   <= q_item.v;
            ath0_reg <= q_item.ath;
            phi0_reg <= q_item.phi;
            for (int k = 1; k <= TL; k++) begin
                ex_d[k]  <= ex_d[k-1];
                ey_d[k]  <= ey_d[k-1];
                eth_d[k] <= eth_d[k-1];
                v_d[k]   <= v_d[k-1];
            end
        end
    end

    aptl_trig u_trig_head (
        .aclk  (aclk),
        .en    (en),
        .ang_i ({{2{ath0_reg[15]}}, ath0_reg, 4'b0}),
        .cos_o (c1),
        .sin_o (s1)
    );

    aptl_trig u_trig_err (
        .aclk  (aclk),
        .en    (en),
        .ang_i ({eth_d[0][16], eth_d[0], 4'b0}),
        .cos_o (c2),
        .sin_o (s2)
    );

    aptl_trig u_trig_steer (
        .aclk  (aclk),
        .en    (en),
        .ang_i ({{4{phi0_reg[13]}}, phi0_reg, 4'b0}),
        .cos_o (c3),
        .sin_o (s3)
    );

    aptl_div u_div (
        .aclk  (aclk),
        .en    (en),
        .sin_i (s3),
        .cos_i (c3),
        .tan_o (tn)
    );

    assign sum_x = 61'(pcex_reg) + 61'(psey_reg) + 61'sd8388608;
    assign sum_y = 61'(pcey_reg) - 61'(psex_reg) + 61'sd8388608;

    // Multiply chain: frame rotation, speed and gain terms
    always_ff @(posedge aclk) begin
        if (en) begin
            pcex_reg <= c1 * ex_d[TL];
            psey_reg <= s1 * ey_d[TL];
            pcey_reg <= c1 * ey_d[TL];
            psex_reg <= s1 * ex_d[TL];
            pvc_reg  <= v_d[TL] * c2;
            pke_reg  <= k3 * eth_d[TL];
            v1_reg   <= v_d[TL];

            exl_reg <= 37'(sum_x >>> 24);
            eyl_reg <= 37'(sum_y >>> 24);
            vc2_reg <= 35'((pvc_reg + 43'sd128) >>> 8);
            kel_reg <= pke_reg * len;
            v2_reg  <= v1_reg;

            kx_reg  <= k1 * exl_reg;
            kye_reg <= ky * eyl_reg;
            vc3_reg <= vc2_reg;
            t3a_reg <= 47'((kel_reg + 51'sd8) >>> 4);
            v3_reg  <= v2_reg;

            u24_reg <= 55'(kx_reg) + 55'(vc3_reg);
            r2_reg  <= 46'((kye_reg + 54'sd128) >>> 8);
            t3b_reg <= t3a_reg;
            v4_reg  <= v3_reg;

            u8_d[0] <= 39'((u24_reg + 55'sd32768) >>> 16);
            t2_d[0] <= r2_reg * len;
            t3_d[0] <= t3b_reg;
            v_e[0]  <= v4_reg;
            for (int k = 1; k <= DLY; k++) begin
                u8_d[k] <= u8_d[k-1];
                t2_d[k] <= t2_d[k-1];
                t3_d[k] <= t3_d[k-1];
                v_e[k]  <= v_e[k-1];
            end
        end
    end

    // Magnitudes, saturation, leading one search, shift and special cases
    always_comb begin
        num_abs = num_reg[64] ? 65'(-num_reg) : 65'(num_reg);
        den_abs = den_reg[54] ? 55'(-den_reg) : 55'(den_reg);
        if (u8m_reg > 39'sd32767) begin
            spd_c = 16'sd32767;
        end else if (u8m_reg < -39'sd32768) begin
            spd_c = -16'sd32768;
        end else begin
            spd_c = u8m_reg[15:0];
        end
        m_or = a3_reg | 64'(b3_reg);
        for (int j = 0; j < 8; j++) begin
            bnz_c[j] = |m_or[8*j +: 8];
            bmsb_c[j] = '0;
            for (int b = 0; b < 8; b++) begin
                if (m_or[8*j + b]) begin
                    bmsb_c[j] = 3'(b);
                end
            end
        end
        msb_c = '0;
        for (int j = 0; j < 8; j++) begin
            if (bnz_reg[j]) begin
                msb_c = {3'(j), bmsb_reg[j]};
            end
        end
        a_sh = rdir_reg ? (a5_reg >> amt_reg) : (a5_reg << amt_reg);
        b_sh = rdir_reg ? (64'(b5_reg) >> amt_reg) : (64'(b5_reg) << amt_reg);
        if (denz5_reg) begin
            spec_c = (a5_reg == '0) ? aptl_pkg::SPEC_ZERO : aptl_pkg::SPEC_MAX;
        end else if (b_sh == '0) begin
            spec_c = aptl_pkg::SPEC_MAX;
        end else begin
            spec_c = aptl_pkg::SPEC_NONE;
        end
    end

    // Ratio stages: numerator, denominator, normalization
    always_ff @(posedge aclk) begin
        if (en) begin
            vt_reg  <= v_e[DLY] * tn;
            t2n_reg <= t2_d[DLY];
            t3n_reg <= t3_d[DLY];
            u8n_reg <= u8_d[DLY];

            num_reg <= 65'(vt_reg) + 65'(t2n_reg) + 65'(t3n_reg);
            den_reg <= {u8n_reg[38:0], 16'b0};
            u8m_reg <= u8n_reg;

            a3_reg    <= num_abs[63:0];
            b3_reg    <= den_abs;
            sneg3_reg <= (num_reg != '0) && (num_reg[64] ^ den_reg[54]);
            zf3_reg   <= (u8m_reg == '0);
            denz3_reg <= (den_reg == '0);
            spd3_reg  <= spd_c;

            a4_reg    <= a3_reg;
            b4_reg    <= b3_reg;
            sneg4_reg <= sneg3_reg;
            zf4_reg   <= zf3_reg;
            denz4_reg <= denz3_reg;
            spd4_reg  <= spd3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bnz_reg <= bnz_c;
            for (int j = 0; j < 8; j++) begin
                bmsb_reg[j] <= bmsb_c[j];
            end
            a5_reg    <= a4_reg;
            b5_reg    <= b4_reg;
            sneg5_reg <= sneg4_reg;
            zf5_reg   <= zf4_reg;
            denz5_reg <= denz4_reg;
            spd5_reg  <= spd4_reg;
            rdir_reg  <= (msb_c > 6'd39);
            amt_reg   <= (msb_c > 6'd39) ? msb_c - 6'd39 : 6'd39 - msb_c;

            cx_reg[0] <= $signed({4'b0, b_sh[39:0]});
            cy_reg[0] <= $signed({4'b0, a_sh[39:0]});
            cz_reg[0] <= '0;
            cs_reg[0] <= spec_c;
            cn_reg[0] <= sneg5_reg;
            cf_reg[0] <= zf5_reg;
            cv_reg[0] <= spd5_reg;
        end
    end

    // Vectoring CORDIC, one step per stage
    for (genvar i = 0; i < STEPS; i++) begin : g_vec
        localparam logic signed [19:0] ZS = 20'(aptl_pkg::ATAN_TAB[i]);
        always_ff @(posedge aclk) begin
            if (en) begin
                if (cy_reg[i] > 0) begin
                    cx_reg[i+1] <= cx_reg[i] + (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] - (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] + ZS;
                end else begin
                    cx_reg[i+1] <= cx_reg[i] - (cy_reg[i] >>> i);
                    cy_reg[i+1] <= cy_reg[i] + (cx_reg[i] >>> i);
                    cz_reg[i+1] <= cz_reg[i] - ZS;
                end
                cs_reg[i+1] <= cs_reg[i];
                cn_reg[i+1] <= cn_reg[i];
                cf_reg[i+1] <= cf_reg[i];
                cv_reg[i+1] <= cv_reg[i];
            end
        end
    end

    // Round, clamp, override and sign the angle
    always_comb begin
        r_c = (cz_reg[STEPS] + 20'sd8) >>> 4;
        case (cs_reg[STEPS])
            aptl_pkg::SPEC_ZERO: st_c = '0;
            aptl_pkg::SPEC_MAX:  st_c = aptl_pkg::STEER_MAX;
            aptl_pkg::SPEC_NONE: begin
                if (r_c < 0) begin
                    st_c = '0;
                end else if (r_c > 20'(aptl_pkg::STEER_MAX)) begin
                    st_c = aptl_pkg::STEER_MAX;
                end else begin
                    st_c = r_c[13:0];
                end
            end
            default: st_c = '0;
        endcase
        if (cn_reg[STEPS]) begin
            st_c = -st_c;
        end
    end

    // Result register; holds while the receiver stalls
    always_ff @(posedge aclk) begin
        if (en) begin
            speed_reg <= cv_reg[STEPS];
            steer_reg <= st_c;
            zf_reg    <= cf_reg[STEPS];
        end
    end

`ifndef SYNTH
    a_steer_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_steer <= aptl_pkg::STEER_MAX && m_steer >= -aptl_pkg::STEER_MAX))
        else $error("steering beyond limit");
    a_zero_speed_steer: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_zflag |-> (m_steer == '0 || m_steer == aptl_pkg::STEER_MAX ||
                                 m_steer == -aptl_pkg::STEER_MAX))
        else $error("zero speed with a finite steering angle");
    a_stall_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !en |=> $stable(vld_reg))
        else $error("pipeline moved while stalled");
`endif

endmodule

### design/ackermann_pose_tracking_law_top.sv
// ----------------------------------------------------------------------------
// ackermann_pose_tracking_law_top: pose tracking law for a car-like vehicle
// Turns actual and target pose, target speed and steering into a speed and
// a steering command.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one pose beat per item; m_* returns one result beat per item,
//   in order. m_tdata holds speed_cmd and steer_cmd, m_tuser the zero speed
//   flag. cfg_* writes the gain and wheel base registers; write them only while idle.
//   cfg_ready is always high and writes to unknown indexes are dropped.
// Throughput: one item per cycle while m_tready does not stall the result.
//   An input beat passes the front register, the queue, the item register,
//   the trig CORDICs, the tangent divider (one quotient bit a stage), the
//   ratio stages, the arctangent CORDIC and the result register.
// Stall: a valid result register holds while m_tready is low and the whole
//   arithmetic pipeline stops with it; the queue behind the front keeps
//   taking beats until it is full, then s_tready drops.
// Reset: aresetn low empties the queue and pipeline and sets every gain and
//   the wheel base to 1.0 (Q8.8 256).
// ----------------------------------------------------------------------------
module ackermann_pose_tracking_law_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    // actual_x, actual_y, actual_heading, target_x, target_y,
    // target_heading, target_speed, target_steer, 2 zero bits
    input  logic [191:0]    s_tdata,
    output logic            m_tvalid,
    input  logic            m_tready,
    // speed_cmd, steer_cmd, 2 zero bits
    output logic [31:0]     m_tdata,
    // zero_speed_flag
    output logic [0:0]      m_tuser,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [7:0]      cfg_index,
    input  logic [15:0]     cfg_wdata
);

    aptl_pkg::cfg_t     cfg_reg;
    aptl_pkg::cfg_t     cfg_next;
    aptl_pkg::item_t    f_item, q_item;
    logic               q_full, q_push, q_pop, q_valid;
    logic signed [15:0] speed;
    logic signed [13:0] steer;
    logic               zflag;

    assign cfg_ready = 1'b1;

    // Decode configuration beats
    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                aptl_pkg::CFG_GAIN_LONG:  cfg_next.gain_long  = cfg_wdata;
                aptl_pkg::CFG_GAIN_LAT:   cfg_next.gain_lat   = cfg_wdata;
                aptl_pkg::CFG_GAIN_HEAD:  cfg_next.gain_head  = cfg_wdata;
                aptl_pkg::CFG_WB_LEN:     cfg_next.wb_len     = cfg_wdata;
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.gain_long  <= aptl_pkg::CFG_RESET_VAL;
            cfg_reg.gain_lat   <= aptl_pkg::CFG_RESET_VAL;
            cfg_reg.gain_head  <= aptl_pkg::CFG_RESET_VAL;
            cfg_reg.wb_len     <= aptl_pkg::CFG_RESET_VAL;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    aptl_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_item   (f_item)
    );

    aptl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .din     (f_item),
        .full    (q_full),
        .pop     (q_pop),
        .valid   (q_valid),
        .dout    (q_item)
    );

    aptl_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_speed  (speed),
        .m_steer  (steer),
        .m_zflag  (zflag)
    );

    assign m_tdata = {2'b0, steer, speed};
    assign m_tuser = zflag;

endmodule

### sim/tb_ackermann_pose_tracking_law_top.sv
// ----------------------------------------------------------------------------
// tb_ackermann_pose_tracking_law_top: self-checking bench of the pose law
// Sends pose beats under random idling and output stalls, predicts each
// speed and steering command with a CORDIC model of its own and compares
// every result beat in order. Gains and wheel base go through several
// settings, the extremes among them.
// ----------------------------------------------------------------------------
module tb_ackermann_pose_tracking_law_top;

    localparam longint GAIN_Q30  = 652032874;
    localparam longint PI_Q16    = 205887;
    localparam longint HPI_Q16   = 102944;
    localparam longint TWOPI_Q16 = 411775;
    localparam longint TAN_LIM   = 64'sd1 <<< 40;
    localparam longint NORM_TOP  = 64'sd1 <<< 40;
    localparam int     DRAIN_CYC = 120;

    typedef struct {
        logic signed [31:0] ax, ay, tx, ty;
        logic signed [15:0] ath, tth, v;
        logic signed [13:0] phi;
    } pose_t;

    typedef struct {
        logic [15:0] speed;
        logic [13:0] steer;
        logic        flag;
    } cmd_t;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [191:0] s_tdata;
    logic         m_tvalid;
    logic         m_tready;
    logic [31:0]  m_tdata;
    logic [0:0]   m_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [7:0]   cfg_index;
    logic [15:0]  cfg_wdata;

    // model copy of the gain registers
    longint k_long, k_lat, k_head, wbase;
    cmd_t   pending_cmds[$];
    int     errors;
    bit     quiet;
    bit     hold_req;

    ackermann_pose_tracking_law_top i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #2000000;
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic longint rnd(input longint x, input int n);
        return (x + (64'sd1 <<< (n - 1))) >>> n;
    endfunction

    // rotation CORDIC: cos and sin in Q.24 of a Q.16 angle
    task automatic sincos(input longint ang, output longint c, output longint s);
        longint x, y, nx;
        bit flip;
        x = GAIN_Q30;
        y = 0;
        flip = 0;
        while (ang > PI_Q16) ang -= TWOPI_Q16;
        while (ang < -PI_Q16) ang += TWOPI_Q16;
        if (ang > HPI_Q16) begin
            ang -= PI_Q16;
            flip = 1;
        end else if (ang < -HPI_Q16) begin
            ang += PI_Q16;
            flip = 1;
        end
        for (int i = 0; i < aptl_pkg::STEPS; i++) begin
            if (ang >= 0) begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                ang -= aptl_pkg::ATAN_TAB[i];
            end else begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                ang += aptl_pkg::ATAN_TAB[i];
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = rnd(x, 6);
        s = rnd(y, 6);
    endtask

    // vectoring CORDIC: atan(a/b) in Q.12, a >= 0, b > 0
    function automatic longint atan_q12(input longint a, input longint b);
        longint x, y, z, nx, r;
        z = 0;
        while (a >= NORM_TOP || b >= NORM_TOP) begin
            a = a >>> 1;
            b = b >>> 1;
        end
        if (b == 0) return aptl_pkg::STEER_MAX;
        while (a < NORM_TOP / 2 && b < NORM_TOP / 2) begin
            a = a * 2;
            b = b * 2;
        end
        x = b;
        y = a;
        for (int i = 0; i < aptl_pkg::STEPS; i++) begin
            if (y > 0) begin
                nx = x + (y >>> i);
                y = y - (x >>> i);
                z += aptl_pkg::ATAN_TAB[i];
            end else begin
                nx = x - (y >>> i);
                y = y + (x >>> i);
                z -= aptl_pkg::ATAN_TAB[i];
            end
            x = nx;
        end
        r = rnd(z, 4);
        if (r < 0) r = 0;
        if (r > aptl_pkg::STEER_MAX) r = aptl_pkg::STEER_MAX;
        return r;
    endfunction

    task automatic predict_cmd(input pose_t p, output cmd_t cmd);
        longint ex, ey, eth, v, c1, s1, c2, s2, c3, s3;
        longint exl, eyl, u24, u8, spd, tn, num, den, st;
        bit sneg;
        ex = longint'(p.tx) - longint'(p.ax);
        ey = longint'(p.ty) - longint'(p.ay);
        eth = longint'(p.tth) - longint'(p.ath);
        v = p.v;
        sincos(longint'(p.ath) * 16, c1, s1);
        exl = rnd(c1 * ex + s1 * ey, 24);
        eyl = rnd(c1 * ey - s1 * ex, 24);
        sincos(eth * 16, c2, s2);
        u24 = k_long * exl + rnd(v * c2, 8);
        u8 = rnd(u24, 16);
        spd = u8;
        if (spd > 32767) spd = 32767;
        if (spd < -32768) spd = -32768;
        sincos(longint'(p.phi) * 16, c3, s3);
        if (c3 == 0) tn = (s3 >= 0) ? TAN_LIM : -TAN_LIM;
        else tn = (s3 * 65536) / c3;
        num = v * tn + rnd(k_lat * eyl, 8) * wbase + rnd(k_head * eth * wbase, 4);
        den = u8 * 65536;
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        sneg = num < 0;
        if (sneg) num = -num;
        if (den == 0) st = (num == 0) ? 0 : aptl_pkg::STEER_MAX;
        else st = atan_q12(num, den);
        if (sneg) st = -st;
        cmd.speed = spd[15:0];
        cmd.steer = st[13:0];
        cmd.flag = (u8 == 0);
    endtask

    // send one pose beat; hold valid until it is taken
    task automatic send_pose(input pose_t p);
        cmd_t cmd;
        bit taken;
        while (!quiet && $urandom_range(99) < 16) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {2'b00, p.phi, p.v, p.tth, p.ty, p.tx, p.ath, p.ay, p.ax};
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        predict_cmd(p, cmd);
        pending_cmds.insert(pending_cmds.size(), cmd);
    endtask

    // valid stays high for back to back writes; the caller drops it
    task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
        bit taken;
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        do begin
            @(negedge aclk);
            taken = cfg_ready;
            @(posedge aclk);
        end while (!taken);
        case (idx)
            aptl_pkg::CFG_GAIN_LONG: k_long = val;
            aptl_pkg::CFG_GAIN_LAT:  k_lat = val;
            aptl_pkg::CFG_GAIN_HEAD: k_head = val;
            aptl_pkg::CFG_WB_LEN:    wbase = val;
            default: ;
        endcase
    endtask

    // drop valid, wait for every result, then let the pipeline empty
    task automatic drain_all();
        s_tvalid <= 1'b0;
        cfg_valid <= 1'b0;
        while (pending_cmds.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYC) @(posedge aclk);
    endtask

    task automatic set_gains(input logic [15:0] kl, kt, kh, wb);
        drain_all();
        write_reg(aptl_pkg::CFG_GAIN_LONG, kl);
        write_reg(aptl_pkg::CFG_GAIN_LAT, kt);
        write_reg(aptl_pkg::CFG_GAIN_HEAD, kh);
        write_reg(aptl_pkg::CFG_WB_LEN, wb);
        cfg_valid <= 1'b0;
    endtask

    function automatic pose_t rand_pose(input bit wide);
        pose_t p;
        int    spread;
        if (wide) begin
            p.ax = $urandom; p.ay = $urandom; p.tx = $urandom; p.ty = $urandom;
            p.ath = 16'($urandom); p.tth = 16'($urandom); p.v = 16'($urandom);
            p.phi = 14'($urandom);
        end else begin
            spread = 1 << $urandom_range(22, 8);
            p.ax = $urandom;
            p.ay = $urandom;
            p.tx = p.ax + $signed($urandom_range(2 * spread)) - spread;
            p.ty = p.ay + $signed($urandom_range(2 * spread)) - spread;
            p.ath = 16'($signed($urandom_range(32767)) - 16384);
            p.tth = 16'(p.ath + $signed($urandom_range(4096)) - 2048);
            p.v = 16'($signed($urandom_range(8192)) - 4096);
            p.phi = 14'($signed($urandom_range(12868)) - 6434);
        end
        return p;
    endfunction

    function automatic pose_t make_pose(input logic signed [31:0] ax, ay, tx, ty,
                                        input logic signed [15:0] ath, tth, v,
                                        input logic signed [13:0] phi);
        pose_t p;
        p.ax = ax; p.ay = ay; p.tx = tx; p.ty = ty;
        p.ath = ath; p.tth = tth; p.v = v; p.phi = phi;
        return p;
    endfunction

    task automatic test_directed();
        // zero speed with no error: flag, steering zero
        send_pose(make_pose(0, 0, 0, 0, 0, 0, 0, 0));
        // zero speed, heading error only: steering at the limit either way
        send_pose(make_pose(5, 5, 5, 5, 0, 100, 0, 0));
        send_pose(make_pose(5, 5, 5, 5, 100, 0, 0, 0));
        // steering at and beyond +-pi/2
        send_pose(make_pose(0, 0, 32'sh10000, 0, 0, 0, 16'sh0100, 14'sd6434));
        send_pose(make_pose(0, 0, 32'sh10000, 0, 0, 0, 16'sh0100, -14'sd6434));
        send_pose(make_pose(0, 0, 32'sh10000, 0, 0, 0, 16'sh0100, 14'sd8191));
        send_pose(make_pose(0, 0, 32'sh10000, 0, 0, 0, 16'sh0100, 14'sh2000));
        // field extremes: speed saturates negative in both, then all fields -1
        send_pose(make_pose(32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
                            16'sh8000, 16'sh7fff, 16'sh7fff, 14'sd8191));
        send_pose(make_pose(32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000,
                            16'sh7fff, 16'sh8000, 16'sh8000, 14'sh2000));
        send_pose(make_pose(-1, -1, -1, -1, -1, -1, -1, -1));
        // negative speed: denominator sign flips
        send_pose(make_pose(0, 0, 0, 32'sh8000, 0, 0, -16'sh0200, 14'sd1000));
        // tiny target speed, forward and reversed
        send_pose(make_pose(0, 0, 0, 0, 0, 0, 16'sd1, 14'sd4000));
        send_pose(make_pose(0, 0, 0, 0, 0, 0, -16'sd1, -14'sd4000));
    endtask

    task automatic test_random(input int count);
        for (int n = 0; n < count; n++) begin
            quiet = (n >= count / 3 && n < count / 3 + 40);
            send_pose(rand_pose($urandom_range(9) < 2));
        end
        quiet = 0;
    endtask

    // hold the output long enough that the queue fills and input stalls
    task automatic test_backpressure();
        hold_req = 1;
        for (int n = 0; n < 120; n++) send_pose(rand_pose(0));
    endtask

    task automatic test_gain_settings();
        set_gains(16'd0, 16'd0, 16'd0, 16'd0);
        test_random(40);
        set_gains(16'hffff, 16'hffff, 16'hffff, 16'hffff);
        test_random(40);
        set_gains(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
        test_random(60);
        // unknown index: must change nothing
        drain_all();
        write_reg(8'd4, 16'h1234);
        write_reg(8'hff, 16'h0000);
        set_gains(16'($urandom_range(1024)), 16'($urandom_range(1024)),
                  16'($urandom_range(1024)), 16'($urandom_range(1024)));
        test_random(60);
    endtask

    // output side: random ready with a long hold on request
    initial begin
        m_tready = 1'b0;
        hold_req = 0;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                repeat (300) @(posedge aclk);
                hold_req = 0;
            end else begin
                m_tready <= quiet || ($urandom_range(99) >= 16);
            end
        end
    end

    // compare each result beat just ahead of the edge that takes it
    always @(negedge aclk) begin
        cmd_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_cmds.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, m_tdata);
                errors++;
            end else begin
                want = pending_cmds.pop_front();
                if (m_tdata[15:0] !== want.speed) begin
                    $display("%0t: speed_cmd expected %h actual %h",
                             $time, want.speed, m_tdata[15:0]);
                    errors++;
                end
                if (m_tdata[29:16] !== want.steer) begin
                    $display("%0t: steer_cmd expected %h actual %h",
                             $time, want.steer, m_tdata[29:16]);
                    errors++;
                end
                if (m_tuser[0] !== want.flag) begin
                    $display("%0t: zero_speed_flag expected %b actual %b",
                             $time, want.flag, m_tuser[0]);
                    errors++;
                end
            end
        end
    end

    initial begin
        errors = 0;
        quiet = 0;
        k_long = 256; k_lat = 256; k_head = 256; wbase = 256;
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_wdata = '0;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_random(100);
        test_backpressure();
        test_gain_settings();
        set_gains(16'd256, 16'd256, 16'd256, 16'd256);
        test_directed();
        drain_all();
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
